/* rtl/sbl_pkg.sv */
`timescale 1ns / 1ps

package sbl_pkg;

	localparam int BAND_COUNT = 7;
	localparam int ROW_COUNT  = 12;
	localparam int LEVEL_W    = 4;
	localparam int BAND_W     = 3;
	localparam int READING_W  = 10;
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 2;

	typedef logic [LEVEL_W-1:0]   level_t;
	typedef logic [BAND_W-1:0]    band_t;
	typedef logic [READING_W-1:0] reading_t;
	typedef logic [ROW_COUNT-1:0] mask_t;

	typedef enum logic [1:0] {
		STYLE_BAR     = 2'd0,
		STYLE_DOT     = 2'd1,
		STYLE_TWO_DOT = 2'd2
	} style_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DISPLAY_STYLE = 2'd0,
		REG_PEAK_ENABLE   = 2'd1,
		REG_HOLD_RELOAD   = 2'd2
	} reg_index_t;

	typedef struct packed {
		style_t display_style;
		logic   peak_enable;
		level_t hold_reload;
	} cfg_t;

	// one classified frame waiting for the state update
	typedef struct packed {
		logic   in_range;
		band_t  band;
		level_t avg;
	} item_t;

	// per-band noise floor subtracted from each reading
	function automatic reading_t noise_offset(input band_t b);
		reading_t off;
		unique case (b)
			3'd0:    off = 10'd25;
			3'd1:    off = 10'd30;
			3'd2:    off = 10'd25;
			3'd3:    off = 10'd35;
			3'd4:    off = 10'd30;
			3'd5:    off = 10'd50;
			3'd6:    off = 10'd65;
			default: off = 10'd0;
		endcase
		return off;
	endfunction

	// logarithmic threshold of level k, k in 1..12
	function automatic logic [7:0] level_threshold(input level_t k);
		logic [7:0] thr;
		unique case (k)
			4'd1:    thr = 8'd4;
			4'd2:    thr = 8'd6;
			4'd3:    thr = 8'd8;
			4'd4:    thr = 8'd11;
			4'd5:    thr = 8'd16;
			4'd6:    thr = 8'd22;
			4'd7:    thr = 8'd32;
			4'd8:    thr = 8'd45;
			4'd9:    thr = 8'd63;
			4'd10:   thr = 8'd89;
			4'd11:   thr = 8'd126;
			4'd12:   thr = 8'd178;
			default: thr = 8'd0;
		endcase
		return thr;
	endfunction

endpackage

/* rtl/spectrum_bar_level_peak_hold_top.sv */
// spectrum bar level with peak hold: one column update of a bar-graph display
// input channel: in_valid / in_stall carry band, reading_first, reading_second;
//   a transfer happens at a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall carry row_mask, bar_level, peak_level;
//   exactly one result per input transfer, in order
// throughput: one item per cycle while out_stall is low; the per-band level,
//   peak and hold counters sit in flip-flops and are read-modify-written on pop
// path: an input is written into a queue entry, then popped into the output
//   register once that is free, and taken at an edge when out_stall is low
// front end quantizes and averages into a two-entry queue, back end updates the
//   band state and registers the lit-row mask
// when the receiver stalls the result holds, the queue absorbs two more items,
//   then in_stall rises until the output is taken
// config: cfg_write with cfg_index / cfg_data, one register per edge, no
//   read-back; write only while no item is in flight
// reset: all band state zero, display_style 1, peak_enable 0, hold_reload 12,
//   queue and output empty
`timescale 1ns / 1ps

module spectrum_bar_level_peak_hold_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [sbl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sbl_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  sbl_pkg::band_t                  band,
	input  sbl_pkg::reading_t               reading_first,
	input  sbl_pkg::reading_t               reading_second,
	output logic                            out_valid,
	input  logic                            out_stall,
	output sbl_pkg::mask_t                  row_mask,
	output sbl_pkg::level_t                 bar_level,
	output sbl_pkg::level_t                 peak_level
);

	// configuration registers
	sbl_pkg::cfg_t cfg_q;

	// queue between front and back
	logic           q_valid;
	sbl_pkg::item_t q_item;
	logic           pop;
	logic [1:0]     q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.display_style <= sbl_pkg::STYLE_DOT;
			cfg_q.peak_enable   <= 1'b0;
			cfg_q.hold_reload   <= 4'd12;
		end else if (cfg_write) begin
			unique case (cfg_index)
				sbl_pkg::REG_DISPLAY_STYLE:
					cfg_q.display_style <= sbl_pkg::style_t'(cfg_data[1:0]);
				sbl_pkg::REG_PEAK_ENABLE:
					cfg_q.peak_enable <= cfg_data[0];
				sbl_pkg::REG_HOLD_RELOAD:
					cfg_q.hold_reload <= cfg_data;
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// front end: quantize both readings, average, classify band, queue
	sbl_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.band           (band),
		.reading_first  (reading_first),
		.reading_second (reading_second),
		.pop            (pop),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_count        (q_count)
	);

	// back end: band state update, row mask, output register
	sbl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_mask   (row_mask),
		.bar_level  (bar_level),
		.peak_level (peak_level)
	);

	// a transfer in never lands on a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> (q_count != 2'd2))
		else $error("queue overflow");

	// a popped item is always offered on the next cycle
	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("popped item not offered");

	// with peaks on the marker never sits below the bar
	a_peak_above: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cfg_q.peak_enable) |=> (peak_level >= bar_level))
		else $error("peak below bar");

	// a lit row needs a nonzero bar or peak
	a_mask_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && row_mask != '0) |-> (bar_level != '0 || peak_level != '0))
		else $error("rows lit with empty levels");

endmodule

/* rtl/sbl_front.sv */
`timescale 1ns / 1ps

module sbl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sbl_pkg::band_t    band,
	input  sbl_pkg::reading_t reading_first,
	input  sbl_pkg::reading_t reading_second,
	input  logic              pop,
	output logic              q_valid,
	output sbl_pkg::item_t    q_item,
	output logic [1:0]        q_count
);

	// reading minus floor, doubled, counted against the threshold ladder
	function automatic sbl_pkg::level_t quantize(input sbl_pkg::reading_t r,
			input sbl_pkg::reading_t off);
		logic [sbl_pkg::READING_W:0] v;
		sbl_pkg::level_t             lvl;
		v   = (r > off) ? {r - off, 1'b0} : '0;
		lvl = '0;
		for (int k = 1; k <= sbl_pkg::ROW_COUNT; k++) begin
			if (v >= {3'b000, sbl_pkg::level_threshold(sbl_pkg::level_t'(k))})
				lvl = lvl + 1'b1;
		end
		return lvl;
	endfunction

	sbl_pkg::reading_t off;
	sbl_pkg::level_t   la;
	sbl_pkg::level_t   lb;
	logic [sbl_pkg::LEVEL_W:0] sum;
	sbl_pkg::item_t    new_item;
	logic              push;

	sbl_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	always_comb begin
		off               = sbl_pkg::noise_offset(band);
		la                = quantize(reading_first, off);
		lb                = quantize(reading_second, off);
		sum               = {1'b0, la} + {1'b0, lb};
		new_item.in_range = (band < sbl_pkg::band_t'(sbl_pkg::BAND_COUNT));
		new_item.band     = band;
		new_item.avg      = (la == '0 || lb == '0) ? '0 : sum[sbl_pkg::LEVEL_W:1];
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];
	assign q_count  = count_q;

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= new_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/sbl_back.sv */
`timescale 1ns / 1ps

module sbl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sbl_pkg::cfg_t   cfg,
	input  logic            q_valid,
	input  sbl_pkg::item_t  q_item,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output sbl_pkg::mask_t  row_mask,
	output sbl_pkg::level_t bar_level,
	output sbl_pkg::level_t peak_level
);

	sbl_pkg::level_t level_q [sbl_pkg::BAND_COUNT];
	sbl_pkg::level_t peak_q  [sbl_pkg::BAND_COUNT];
	sbl_pkg::level_t hold_q  [sbl_pkg::BAND_COUNT];

	logic            out_valid_q;
	sbl_pkg::mask_t  row_mask_q;
	sbl_pkg::level_t bar_level_q;
	sbl_pkg::level_t peak_level_q;

	sbl_pkg::band_t  idx;
	sbl_pkg::level_t old_lvl;
	sbl_pkg::level_t dec_lvl;
	sbl_pkg::level_t lvl_n;
	sbl_pkg::level_t peak_n;
	sbl_pkg::level_t hold_n;
	sbl_pkg::level_t top;
	logic            marker;
	logic [4:0]      run;
	sbl_pkg::mask_t  mask_n;

	assign pop = q_valid && (!out_valid_q || !out_stall);

	always_comb begin
		idx     = q_item.in_range ? q_item.band : '0;
		old_lvl = level_q[idx];
		dec_lvl = (old_lvl != '0) ? old_lvl - 1'b1 : '0;
		if (cfg.peak_enable)
			lvl_n = q_item.avg;
		else
			lvl_n = (q_item.avg > dec_lvl) ? q_item.avg : dec_lvl;
		if (lvl_n > sbl_pkg::level_t'(sbl_pkg::ROW_COUNT))
			lvl_n = sbl_pkg::level_t'(sbl_pkg::ROW_COUNT);

		peak_n = peak_q[idx];
		hold_n = hold_q[idx];
		marker = 1'b0;
		if (cfg.peak_enable) begin
			if (peak_q[idx] > lvl_n) begin
				if (hold_q[idx] != '0) begin
					hold_n = hold_q[idx] - 1'b1;
					marker = 1'b1;
				end else begin
					peak_n = peak_q[idx] - 1'b1;
					hold_n = cfg.hold_reload;
				end
			end else begin
				peak_n = lvl_n;
				hold_n = cfg.hold_reload;
			end
		end

		unique case (cfg.display_style)
			sbl_pkg::STYLE_DOT:     run = 5'd1;
			sbl_pkg::STYLE_TWO_DOT: run = 5'd2;
			default:                run = 5'(sbl_pkg::ROW_COUNT);
		endcase

		// marker over an empty bar starts the run at the peak itself
		top = (marker && lvl_n == '0) ? peak_n : lvl_n;
		for (int k = 0; k < sbl_pkg::ROW_COUNT; k++) begin
			mask_n[k] = ((5'(k) < {1'b0, top}) && ((5'(k) + run) >= {1'b0, top}))
				|| (marker && lvl_n != '0 && (5'(k) + 5'd1) == {1'b0, peak_n});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sbl_pkg::BAND_COUNT; i++) begin
				level_q[i] <= '0;
				peak_q[i]  <= '0;
				hold_q[i]  <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (pop && q_item.in_range) begin
				level_q[idx] <= lvl_n;
				peak_q[idx]  <= peak_n;
				hold_q[idx]  <= hold_n;
			end
			if (pop)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			row_mask_q   <= q_item.in_range ? mask_n : '0;
			bar_level_q  <= q_item.in_range ? lvl_n : '0;
			peak_level_q <= q_item.in_range ? peak_n : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign row_mask   = row_mask_q;
	assign bar_level  = bar_level_q;
	assign peak_level = peak_level_q;

endmodule
